// File: hw/rtl/plist_pkg.sv
// ---------------------------------------------------------------------------
// Positional list engine package
// Shared widths, operation and status codes, sequencer states and the result
// record passed from the sequencer to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

	localparam int DATA_W       = 32;
	localparam int OP_W         = 3;
	localparam int POS_W        = 6;
	localparam int CNT_OUT_W    = 7;
	localparam int STATUS_W     = 2;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_INSERT_AT  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_REMOVE_AT  = 3'd5,
		OP_UPDATE_AT  = 3'd6,
		OP_NOP        = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_DOWN,
		S_WRITE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic idle;
		logic done;
	} ctl_stat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		status_t                  status;
		logic [CNT_OUT_W-1:0]     count_now;
	} res_t;

endpackage

`default_nettype wire

// File: hw/rtl/plist_if.sv
// ---------------------------------------------------------------------------
// Positional list engine channels
// Request and response channels with a valid/ready handshake; one transaction
// moves at a rising edge where valid and ready are both high.
// ---------------------------------------------------------------------------
`default_nettype none

interface plist_req_if
	import plist_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value_in;

	modport source (output valid, output opcode, output position, output value_in,
		input ready);
	modport sink (input valid, input opcode, input position, input value_in,
		output ready);
endinterface

interface plist_rsp_if
	import plist_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value_out;
	logic [STATUS_W-1:0]      status;
	logic [CNT_OUT_W-1:0]     count_now;

	modport source (output valid, output value_out, output status, output count_now,
		input ready);
	modport sink (input valid, input value_out, input status, input count_now,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/plist_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are undefined until
// written.
// ---------------------------------------------------------------------------
`default_nettype none

module plist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/plist_ctrl.sv
// ---------------------------------------------------------------------------
// Positional list sequencer
// Decodes one request, checks it against the entry count and walks the entry
// memory one entry a cycle to open or close a gap, then reports the result.
// ---------------------------------------------------------------------------
`default_nettype none

module plist_ctrl
	import plist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	localparam int AW      = $clog2(CAPACITY),
	localparam int CW      = $clog2(CAPACITY + 1),
	localparam int XW      = CW + POS_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [OP_W-1:0]          opcode,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic signed [DATA_W-1:0] value_in,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  wire logic [DATA_W-1:0]        rd_data,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [DATA_W-1:0]             wr_data,
	output ctl_stat_t                     stat,
	output res_t                          res
);

	fsm_t              state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cnt_next_q;
	logic [AW-1:0]     at_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     stop_q;
	logic [AW-1:0]     pend_addr_q;
	logic              pend_q;
	logic              grab_q;
	logic              wval_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] got_q;
	status_t           status_q;

	op_t               dec_op;
	logic [XW-1:0]     n_x;
	logic [XW-1:0]     nm1_x;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     at_x;
	logic              is_full;
	logic              is_empty;
	fsm_t              dec_next;
	status_t           dec_status;
	logic              dec_wval;
	logic [AW-1:0]     dec_ptr;
	logic [AW-1:0]     dec_stop;
	logic [CW-1:0]     dec_cnt;

	always_comb begin
		dec_op   = op_t'(opcode);
		n_x      = XW'(count_q);
		nm1_x    = n_x - XW'(1);
		pos_x    = XW'(position);
		is_full  = (count_q == CW'(CAPACITY));
		is_empty = (count_q == '0);
		case (dec_op)
			OP_PUSH_FRONT, OP_POP_FRONT: at_x = '0;
			OP_PUSH_BACK:                at_x = n_x;
			OP_POP_BACK:                 at_x = nm1_x;
			default:                     at_x = pos_x;
		endcase
	end

	always_comb begin
		dec_next   = S_DONE;
		dec_status = ST_OK;
		dec_wval   = 1'b0;
		dec_ptr    = at_x[AW-1:0];
		dec_stop   = nm1_x[AW-1:0];
		dec_cnt    = count_q;
		case (dec_op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
				if (is_full) begin
					dec_status = ST_FULL;
				end else if (at_x > n_x) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_wval = 1'b1;
					dec_cnt  = CW'(count_q + CW'(1));
					dec_ptr  = nm1_x[AW-1:0];
					dec_stop = at_x[AW-1:0];
					dec_next = (at_x == n_x) ? S_WRITE : S_UP;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else if (at_x >= n_x) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_cnt  = CW'(count_q - CW'(1));
					dec_next = S_DOWN;
				end
			end
			OP_UPDATE_AT: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else if (at_x >= n_x) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_wval = 1'b1;
					dec_next = S_WRITE;
				end
			end
			default: begin
				dec_next = S_DONE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = dec_next;
				end
			end
			S_UP, S_DOWN: begin
				if (ptr_q == stop_q) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (!pend_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = (state_q == S_UP) || (state_q == S_DOWN);
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = pend_addr_q;
		wr_data = rd_data;
		if (pend_q) begin
			wr_en = !grab_q;
		end else if (state_q == S_WRITE) begin
			wr_en   = wval_q;
			wr_addr = at_q;
			wr_data = val_q;
		end
		stat.idle     = (state_q == S_IDLE);
		stat.done     = (state_q == S_DONE);
		res.value_out = got_q;
		res.status    = status_q;
		res.count_now = CNT_OUT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			grab_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= rd_en;
			grab_q  <= (state_q == S_DOWN) && (ptr_q == at_q);
			if ((state_q == S_WRITE) && !pend_q) begin
				count_q <= cnt_next_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= (state_q == S_UP) ? AW'(ptr_q + AW'(1)) : AW'(ptr_q - AW'(1));
		if ((state_q == S_IDLE) && start) begin
			status_q   <= dec_status;
			at_q       <= at_x[AW-1:0];
			ptr_q      <= dec_ptr;
			stop_q     <= dec_stop;
			wval_q     <= dec_wval;
			val_q      <= value_in;
			cnt_next_q <= dec_cnt;
			got_q      <= '0;
		end else begin
			if (state_q == S_UP) begin
				ptr_q <= AW'(ptr_q - AW'(1));
			end else if (state_q == S_DOWN) begin
				ptr_q <= AW'(ptr_q + AW'(1));
			end
			if (pend_q && grab_q) begin
				got_q <= rd_data;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_engine_unit.sv
// ---------------------------------------------------------------------------
// Positional list engine
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in one RAM.
//
// A request transaction on req carries an opcode, a position and a value;
// each request gives exactly one response transaction on rsp with the
// extracted value, a status code and the entry count after the operation.
// Requests are handled one at a time. An operation that moves entries walks
// the RAM one entry a cycle through its single read and write ports: an
// insert or an extract walks the entries from its position to the end of
// the list, an append or overwrite writes one entry without a walk, and a
// rejected request goes straight to its response.
// The response sits in an output register; a new request is taken while the
// previous response is being accepted, so a stalled receiver only holds off
// further requests and never loses a response. Reset empties the list at
// once; entry contents are not cleared and are never read before written.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit
	import plist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	plist_req_if.sink  req,
	plist_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	ctl_stat_t         stat;
	res_t              res;
	res_t              rsp_q;
	logic              rsp_valid_q;
	logic              start;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign req.ready = stat.idle && (!rsp_valid_q || rsp.ready);
	assign start     = req.valid && req.ready;

	plist_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.opcode   (req.opcode),
		.position (req.position),
		.value_in (req.value_in),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.stat     (stat),
		.res      (res)
	);

	plist_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = rsp_q.value_out;
	assign rsp.status    = rsp_q.status;
	assign rsp.count_now = rsp_q.count_now;

	a_done_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (!rsp_valid_q || rsp.ready))
		else $error("Result completed while the output register was still occupied.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("A second request was taken while one was still in progress.");

	a_failed_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |-> (rsp.value_out == '0))
		else $error("A failed operation returned a non-zero value.");

endmodule

`default_nettype wire

// File: sim/positional_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Positional list engine testbench
// Drives a short table of list operations and then about seven hundred
// random ones through the request channel. The random traffic swings the list
// between empty and full. A list model in the bench predicts each response not
// fixed by a table row; all are compared field by field in order of arrival.
// ---------------------------------------------------------------------------

module positional_list_engine_unit_tb;
	import plist_pkg::*;

	typedef enum int {
		LOAD_FILL,
		LOAD_DRAIN,
		LOAD_EVEN
	} traffic_t;

	typedef struct packed {
		op_t                      op;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
		logic                     fixed_exp;
		logic signed [DATA_W-1:0] exp_value;
		status_t                  exp_status;
		logic [CNT_OUT_W-1:0]     exp_count;
	} table_row_t;

	localparam int TABLE_ROWS = 25;
	localparam table_row_t OP_TABLE [0:TABLE_ROWS-1] = '{
		'{OP_POP_FRONT,  6'd0,  32'sd0,           1'b1, 32'sd0,           ST_EMPTY,  7'd0},
		'{OP_POP_BACK,   6'd0,  32'sd0,           1'b1, 32'sd0,           ST_EMPTY,  7'd0},
		'{OP_REMOVE_AT,  6'd0,  32'sd0,           1'b1, 32'sd0,           ST_EMPTY,  7'd0},
		'{OP_UPDATE_AT,  6'd0,  32'sd5,           1'b1, 32'sd0,           ST_EMPTY,  7'd0},
		'{OP_INSERT_AT,  6'd1,  32'sd9,           1'b1, 32'sd0,           ST_BADPOS, 7'd0},
		'{OP_NOP,        6'd63, -32'sd1,          1'b1, 32'sd0,           ST_OK,     7'd0},
		'{OP_PUSH_BACK,  6'd0,  32'sh7fffffff,    1'b1, 32'sd0,           ST_OK,     7'd1},
		'{OP_POP_BACK,   6'd0,  32'sd0,           1'b1, 32'sh7fffffff,    ST_OK,     7'd0},
		'{OP_PUSH_FRONT, 6'd0,  32'sh80000000,    1'b1, 32'sd0,           ST_OK,     7'd1},
		'{OP_INSERT_AT,  6'd1,  -32'sd1,          1'b1, 32'sd0,           ST_OK,     7'd2},
		'{OP_PUSH_BACK,  6'd0,  32'sh7fffffff,    1'b1, 32'sd0,           ST_OK,     7'd3},
		'{OP_INSERT_AT,  6'd0,  32'sh12345678,    1'b1, 32'sd0,           ST_OK,     7'd4},
		'{OP_INSERT_AT,  6'd63, 32'sd1,           1'b1, 32'sd0,           ST_BADPOS, 7'd4},
		'{OP_REMOVE_AT,  6'd4,  32'sd0,           1'b1, 32'sd0,           ST_BADPOS, 7'd4},
		'{OP_UPDATE_AT,  6'd4,  32'sd7,           1'b1, 32'sd0,           ST_BADPOS, 7'd4},
		'{OP_UPDATE_AT,  6'd63, 32'sd7,           1'b1, 32'sd0,           ST_BADPOS, 7'd4},
		'{OP_UPDATE_AT,  6'd2,  32'sh55aa55aa,    1'b1, 32'sd0,           ST_OK,     7'd4},
		'{OP_REMOVE_AT,  6'd2,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_INSERT_AT,  6'd3,  32'shdeadbeef,    1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_POP_BACK,   6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_POP_FRONT,  6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_REMOVE_AT,  6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_NOP,        6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_REMOVE_AT,  6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0},
		'{OP_POP_FRONT,  6'd0,  32'sd0,           1'b0, 32'sd0,           ST_OK,     7'd0}
	};

	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 140;

	logic clk;
	logic arst_n;

	plist_req_if req ();
	plist_rsp_if rsp ();

	positional_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic signed [DATA_W-1:0] list_entries [0:CAPACITY_DEF-1];
	int unsigned              list_len;
	res_t                     pending_results [$];
	int unsigned              requests_taken;
	int unsigned              mismatches;
	logic                     no_idle;
	logic                     hold_sink;
	logic                     offer_fixed;
	res_t                     offer_expect;

	always #5 clk = ~clk;

	function automatic res_t apply_list_op(input op_t op, input int unsigned p,
		input logic signed [DATA_W-1:0] v);
		res_t        r;
		int unsigned at;
		int unsigned i;
		r.value_out = '0;
		r.status    = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
				at = (op == OP_PUSH_FRONT) ? 0 : (op == OP_PUSH_BACK) ? list_len : p;
				if (list_len >= CAPACITY_DEF) begin
					r.status = ST_FULL;
				end else if (at > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (i = list_len; i > at; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[at] = v;
					list_len++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at = (op == OP_POP_FRONT) ? 0 : (op == OP_POP_BACK) ? list_len - 1 : p;
					if (at >= list_len) begin
						r.status = ST_BADPOS;
					end else begin
						r.value_out = list_entries[at];
						for (i = at; i + 1 < list_len; i++)
							list_entries[i] = list_entries[i+1];
						list_len--;
					end
				end
			end
			OP_UPDATE_AT: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (p >= list_len)
					r.status = ST_BADPOS;
				else
					list_entries[p] = v;
			end
			default: begin
			end
		endcase
		r.count_now = list_len[CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_response();
		res_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch("response transaction with none outstanding");
		end else begin
			want = pending_results.pop_front();
			if (rsp.value_out !== want.value_out)
				flag_mismatch($sformatf("value_out %0d, predicted %0d",
					rsp.value_out, want.value_out));
			if (rsp.status !== want.status)
				flag_mismatch($sformatf("status %0d, predicted %0d", rsp.status, want.status));
			if (rsp.count_now !== want.count_now)
				flag_mismatch($sformatf("count_now %0d, predicted %0d",
					rsp.count_now, want.count_now));
		end
	endtask

	always @(posedge clk) begin
		res_t predicted;
		if (rsp.valid && rsp.ready)
			check_response();
		if (req.valid && req.ready) begin
			predicted = apply_list_op(op_t'(req.opcode), 32'(req.position), req.value_in);
			pending_results.push_back(offer_fixed ? offer_expect : predicted);
			requests_taken++;
		end
	end

	task automatic offer(input op_t op, input logic [POS_W-1:0] p,
		input logic signed [DATA_W-1:0] v, input logic fixed, input res_t want);
		int unsigned seen;
		if (!no_idle) begin
			while ($urandom_range(99) < 10) begin
				req.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req.valid    <= 1'b1;
		req.opcode   <= op;
		req.position <= p;
		req.value_in <= v;
		offer_fixed  = fixed;
		offer_expect = want;
		seen         = requests_taken;
		do @(negedge clk); while (requests_taken == seen);
	endtask

	task automatic wait_all_results();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic make_random_request(input traffic_t mode, output op_t op,
		output logic [POS_W-1:0] p, output logic signed [DATA_W-1:0] v);
		int unsigned roll;
		int unsigned ins_pct;
		int unsigned ext_pct;
		int unsigned top;
		ins_pct = (mode == LOAD_FILL) ? 70 : (mode == LOAD_DRAIN) ? 15 : 40;
		ext_pct = (mode == LOAD_FILL) ? 15 : (mode == LOAD_DRAIN) ? 70 : 40;
		roll    = $urandom_range(99);
		if (roll < ins_pct)
			op = op_t'($urandom_range(2));
		else if (roll < ins_pct + ext_pct)
			op = op_t'(3 + $urandom_range(2));
		else if (roll < 97)
			op = OP_UPDATE_AT;
		else
			op = OP_NOP;

		top  = (list_len > 63) ? 63 : list_len;
		roll = $urandom_range(9);
		if (roll < 2)
			p = POS_W'($urandom_range(63));
		else if (roll == 2)
			p = POS_W'(top);
		else if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT_AT)
			p = POS_W'($urandom_range(top));
		else if (list_len == 0)
			p = POS_W'($urandom_range(63));
		else
			p = POS_W'($urandom_range(list_len - 1));

		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: v = 32'sh80000000;
				1: v = 32'sh7fffffff;
				2: v = 32'sd0;
				default: v = -32'sd1;
			endcase
		end else begin
			v = $urandom;
		end
	endtask

	initial begin : sink_side
		int k;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				rsp.ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
				hold_sink = 1'b0;
			end
			rsp.ready <= no_idle || ($urandom_range(99) >= 10);
		end
	end

	initial begin : source_side
		int         row;
		int         ph;
		int         n;
		traffic_t   mode;
		op_t        op;
		logic [POS_W-1:0]         p;
		logic signed [DATA_W-1:0] v;
		res_t       want;

		clk            = 1'b0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.opcode     = OP_NOP;
		req.position   = '0;
		req.value_in   = '0;
		list_len       = 0;
		requests_taken = 0;
		mismatches     = 0;
		no_idle        = 1'b0;
		hold_sink      = 1'b0;
		offer_fixed    = 1'b0;
		offer_expect   = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < TABLE_ROWS; row++) begin
			want.value_out = OP_TABLE[row].exp_value;
			want.status    = OP_TABLE[row].exp_status;
			want.count_now = OP_TABLE[row].exp_count;
			offer(OP_TABLE[row].op, OP_TABLE[row].pos, OP_TABLE[row].value,
				OP_TABLE[row].fixed_exp, want);
		end
		wait_all_results();

		want = '0;
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0, 3: mode = LOAD_FILL;
				2: mode = LOAD_EVEN;
				default: mode = LOAD_DRAIN;
			endcase
			no_idle = (ph == 2);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == 40)
					hold_sink = 1'b1;
				make_random_request(mode, op, p, v);
				offer(op, p, v, 1'b0, want);
			end
			no_idle = 1'b0;
			wait_all_results();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("[positional_list_engine_unit] OK");
		else
			$display("[positional_list_engine_unit] ERROR");
		$finish;
	end

	initial begin : run_limit
		#5_000_000;
		$display("[positional_list_engine_unit] ERROR");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/plist_pkg.sv
hw/rtl/plist_if.sv
hw/rtl/plist_ram.sv
hw/rtl/plist_ctrl.sv
hw/rtl/positional_list_engine_unit.sv
sim/positional_list_engine_unit_tb.sv
